@@ rtl/core/astr_pkg.sv @@
// ----------------------------------------------------------------------------
// Alternating split transposition package
// Shared payload types, widths and register indexes of the transposition core.
// ----------------------------------------------------------------------------
package astr_pkg;

	localparam int BYTE_W      = 8;
	localparam int MAX_LEN_DEF = 64;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_in;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_out;
		logic              overflow;
	} out_item_t;

endpackage

@@ rtl/core/astr_ram.sv @@
// ----------------------------------------------------------------------------
// Alternating split transposition byte buffer
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module astr_ram #(
	parameter int DEPTH = astr_pkg::MAX_LEN_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [astr_pkg::BYTE_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [astr_pkg::BYTE_W-1:0] rdata
);
	import astr_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/alternating_split_transposition_core.sv @@
// ----------------------------------------------------------------------------
// Alternating split transposition core
// Buffers a message, permutes it a configured number of rounds, emits it.
// ----------------------------------------------------------------------------
// Input transactions carry one byte and a last flag; bytes are taken one per
// cycle while the core is loading. Bytes beyond MAX_LEN are dropped and mark
// the message as overflowed. On the last byte the input stalls until the whole
// result has left. With len stored bytes, each round streams the buffer from
// one memory into the other, one byte per cycle, followed by a drain state
// that completes the last write; rounds are skipped when rounds is zero or
// len is one. A prep state then fetches the first byte; the output then
// offers one byte per cycle, last_out on the final one. When the receiver
// stalls, the offered transaction holds and the read address is held, so the
// next byte follows in the cycle after the stall drops. Reset returns the
// core to loading with an empty, clean buffer; memory contents are not
// cleared. Configuration must be written by the user only while the core is
// loading with nothing buffered; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module alternating_split_transposition_core #(
	parameter int MAX_LEN = astr_pkg::MAX_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [astr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [astr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  astr_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output astr_pkg::out_item_t             out_data
);
	import astr_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	typedef enum logic [4:0] {
		S_LOAD  = 5'b00001,
		S_ROUND = 5'b00010,
		S_DRAIN = 5'b00100,
		S_PREP  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	// Source address of output position k for one round.
	function automatic logic [AW-1:0] src_index(input logic [AW-1:0] k,
	                                            input logic [CW-1:0] len,
	                                            input logic          dec);
		logic [CW-1:0] half;
		logic [CW:0]   idx;
		begin
			half = len >> 1;
			if (!dec) begin
				if ((CW+1)'(k) < (CW+1)'(half)) begin
					idx = ((CW+1)'(k) << 1) + (CW+1)'(1);
				end else begin
					idx = ((CW+1)'(k) - (CW+1)'(half)) << 1;
				end
			end else begin
				if (k[0]) begin
					idx = (CW+1)'(k >> 1);
				end else begin
					idx = (CW+1)'(half) + (CW+1)'(k >> 1);
				end
			end
			src_index = idx[AW-1:0];
		end
	endfunction

	state_t            state_q;
	logic [7:0]        rounds_q;
	logic              dec_q;
	logic [CW-1:0]     fill_q;
	logic              ovf_q;
	logic              cur_q;
	logic [AW-1:0]     k_q;
	logic [7:0]        rcnt_q;
	logic              w_v_s1;
	logic [AW-1:0]     w_idx_s1;

	logic              in_acc;
	logic              out_acc;
	logic              room;
	logic              load_we;
	logic              is_last;
	logic [CW-1:0]     fill_nxt;
	logic [AW-1:0]     raddr;
	logic [BYTE_W-1:0] rd0;
	logic [BYTE_W-1:0] rd1;
	logic [BYTE_W-1:0] rd_cur;
	logic              we0;
	logic              we1;
	logic [AW-1:0]     wa0;
	logic [AW-1:0]     wa1;
	logic [BYTE_W-1:0] wd0;
	logic [BYTE_W-1:0] wd1;

	assign in_stall  = (state_q != S_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == S_EMIT);
	assign out_acc   = out_valid && !out_stall;
	assign room      = (fill_q < CW'(MAX_LEN));
	assign load_we   = in_acc && room;
	assign fill_nxt  = room ? (fill_q + CW'(1)) : fill_q;
	assign is_last   = (CW'(k_q) == (fill_q - CW'(1)));
	assign rd_cur    = cur_q ? rd1 : rd0;

	always_comb begin
		unique case (state_q)
			S_ROUND: raddr = src_index(k_q, fill_q, dec_q);
			S_EMIT:  raddr = (out_acc && !is_last) ? (k_q + AW'(1)) : k_q;
			default: raddr = '0;
		endcase
	end

	// Loading writes the current buffer; a round writes the other one.
	always_comb begin
		we0 = (load_we && !cur_q) || (w_v_s1 && cur_q);
		we1 = (load_we && cur_q) || (w_v_s1 && !cur_q);
		wa0 = load_we ? fill_q[AW-1:0] : w_idx_s1;
		wa1 = wa0;
		wd0 = load_we ? in_data.data_byte : rd_cur;
		wd1 = wd0;
	end

	astr_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_ram0 (
		.clk   (clk),
		.we    (we0),
		.waddr (wa0),
		.wdata (wd0),
		.raddr (raddr),
		.rdata (rd0)
	);

	astr_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_ram1 (
		.clk   (clk),
		.we    (we1),
		.waddr (wa1),
		.wdata (wd1),
		.raddr (raddr),
		.rdata (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q <= '0;
			dec_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ROUNDS:  rounds_q <= cfg_wdata[7:0];
				CFG_DECRYPT: dec_q    <= cfg_wdata[0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			cur_q   <= 1'b0;
			k_q     <= '0;
			rcnt_q  <= '0;
			w_v_s1  <= 1'b0;
		end else begin
			w_v_s1 <= (state_q == S_ROUND);
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						fill_q <= fill_nxt;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (in_data.last_in) begin
							k_q    <= '0;
							rcnt_q <= rounds_q;
							if ((rounds_q != 8'd0) && (fill_nxt >= CW'(2))) begin
								state_q <= S_ROUND;
							end else begin
								state_q <= S_PREP;
							end
						end
					end
				end
				S_ROUND: begin
					if (is_last) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				S_DRAIN: begin
					cur_q <= ~cur_q;
					k_q   <= '0;
					if (rcnt_q == 8'd1) begin
						state_q <= S_PREP;
					end else begin
						rcnt_q  <= rcnt_q - 8'd1;
						state_q <= S_ROUND;
					end
				end
				S_PREP: begin
					k_q     <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_acc) begin
						if (is_last) begin
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							k_q <= k_q + AW'(1);
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		w_idx_s1 <= k_q;
	end

	always_comb begin
		out_data.out_byte = rd_cur;
		out_data.last_out = is_last;
		out_data.overflow = ovf_q;
	end

endmodule
